// ===== hdl/rgbdith_pkg.sv =====
// Shared constants for the RGB error-diffusion dither core.
package rgbdith_pkg;

  // Sample and configuration widths
  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Frame height limit and the row counter that covers it
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;

  // Full-scale output value
  localparam int PIX_MAX = 255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

  // Register values after reset
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [PIX_W-1:0]      RST_THRESHOLD    = 8'd128;

endpackage

// ===== hdl/rgbdith_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module rgbdith_ram #(
  parameter int WIDTH  = 30,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/rgb_error_diffusion_dither_core.sv =====
// Top level: Floyd-Steinberg error diffusion on RGB pixels, one bit per channel out.
//
//   port group | dir | beat contents
//   -----------+-----+---------------------------------------------------------
//   in_*       | in  | in_red_in, in_green_in, in_blue_in (8 b each), raster order
//   out_*      | out | out_red_out, out_green_out, out_blue_out, out_end_of_frame
//   cfg_*      | in  | cfg_idx selects width / height / threshold, cfg_wdata 11 b
//
// One pixel per clock sustained while no stall holds the flow.
// The error line buffer is two RAM banks (even / odd columns) so the last column
// can write both of its entries in the same cycle; reads forward from a same-cycle write.
// After reset a clearing pass zeroes the line buffer, during which in_stall
// is high. Reset is synchronous, active low.
// An output stall holds the result register and the compute stage, then in_stall.
module rgb_error_diffusion_dither_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int ERROR_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [rgbdith_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [rgbdith_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // pixel input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rgbdith_pkg::PIX_W-1:0]        in_red_in,
  input  logic [rgbdith_pkg::PIX_W-1:0]        in_green_in,
  input  logic [rgbdith_pkg::PIX_W-1:0]        in_blue_in,
  // dithered output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_red_out,
  output logic                                 out_green_out,
  output logic                                 out_blue_out,
  output logic                                 out_end_of_frame
);

  import rgbdith_pkg::*;

  localparam int E   = ERROR_BITS;
  localparam int PW  = ERROR_BITS + 6;            // working width of error math
  localparam int CW  = $clog2(MAX_WIDTH);         // column index
  localparam int BD  = (MAX_WIDTH + 1) / 2;       // entries per bank
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1; // bank address
  localparam int WW  = 3 * ERROR_BITS;            // one buffer word, three channels

  // Saturate to the signed error range
  function automatic logic signed [E-1:0] sat_e(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = PW'(2 ** (E - 1) - 1);
    lo = PW'(-(2 ** (E - 1)));
    if (v > hi) begin
      return E'(hi);
    end else if (v < lo) begin
      return E'(lo);
    end
    return E'(v);
  endfunction

  // Divide by 16, truncating toward zero
  function automatic logic signed [PW-1:0] div16(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] bias;
    bias = PW'(15);
    if (v < 0) begin
      return (v + bias) >>> 4;
    end
    return v >>> 4;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [CFG_DATA_W-1:0] img_w_r;
  logic [CFG_DATA_W-1:0] img_h_r;
  logic [PIX_W-1:0]      thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      thr_r   <= RST_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_wdata;
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_wdata;
        CFG_THRESHOLD:    thr_r   <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  logic s1_valid_r;
  logic out_valid_r;
  logic clr_active_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_active_r || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Stage 0: frame position, last column / row
  logic [CW-1:0]    col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;
  logic [CW-1:0]    wlast;
  logic [ROW_W-1:0] hlast;
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic             last_col;
  logic             last_row;

  always_comb begin
    if (img_w_r == '0) begin
      wlast = '0;
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(img_w_r - 11'd1);
    end
    if (img_h_r == '0) begin
      hlast = '0;
    end else if (32'(img_h_r) > MAX_HEIGHT) begin
      hlast = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hlast = ROW_W'(img_h_r - 11'd1);
    end
    col      = (col_cnt_r > wlast) ? wlast : col_cnt_r;
    row      = (row_cnt_r > hlast) ? hlast : row_cnt_r;
    last_col = (col == wlast);
    last_row = (row == hlast);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col_cnt_r <= col + CW'(1);
        row_cnt_r <= row;
      end
    end
  end

  // Stage 1 holding registers
  logic [PIX_W-1:0] s1_pix_r [3];
  logic [CW-1:0]    s1_col_r;
  logic             s1_last_col_r;
  logic             s1_eof_r;
  logic             s1_row_nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r[0]   <= in_red_in;
      s1_pix_r[1]   <= in_green_in;
      s1_pix_r[2]   <= in_blue_in;
      s1_col_r      <= col;
      s1_last_col_r <= last_col;
      s1_eof_r      <= last_col && last_row;
      s1_row_nz_r   <= (row != '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer: even / odd column banks
  logic [BAW-1:0] rd_addr;
  logic [BAW-1:0] clr_cnt_r;
  logic           bank_we   [2];
  logic [BAW-1:0] bank_wa   [2];
  logic [WW-1:0]  bank_wd   [2];
  logic [WW-1:0]  bank_rd   [2];
  logic           wr_hit    [2];
  logic [BAW-1:0] wr_addr_n [2];
  logic [WW-1:0]  wr_data_n [2];
  logic           fwd_hit_r [2];
  logic [WW-1:0]  fwd_data_r [2];

  assign rd_addr = BAW'(col >> 1);

  for (genvar b = 0; b < 2; b++) begin : g_bank
    rgbdith_ram #(
      .WIDTH  (WW),
      .DEPTH  (BD),
      .ADDR_W (BAW)
    ) u_ram (
      .clk     (clk),
      .wr_en   (bank_we[b]),
      .wr_addr (bank_wa[b]),
      .wr_data (bank_wd[b]),
      .rd_en   (in_acc),
      .rd_addr (rd_addr),
      .rd_data (bank_rd[b])
    );
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_cnt_r == BAW'(BD - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + BAW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: per-channel threshold and error spread
  logic [WW-1:0]          buf_word;
  logic signed [E-1:0]    buf_ch  [3];
  logic signed [PW-1:0]   sum_w   [3];
  logic signed [PW-1:0]   err_w   [3];
  logic [2:0]             bit_w;
  logic signed [PW-1:0]   thr_x;
  logic signed [E-1:0]    rc_r    [3];
  logic signed [E-1:0]    pb0_r   [3];
  logic signed [E-1:0]    pb1_r   [3];
  logic signed [E-1:0]    rc_nxt  [3];
  logic signed [E-1:0]    pb0_nxt [3];
  logic signed [E-1:0]    pb1_nxt [3];
  logic signed [E-1:0]    pb0_new [3];
  logic [WW-1:0]          left_word;
  logic [WW-1:0]          cur_word;

  assign buf_word = fwd_hit_r[s1_col_r[0]] ? fwd_data_r[s1_col_r[0]]
                                           : bank_rd[s1_col_r[0]];
  assign thr_x    = signed'(PW'(thr_r));

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      buf_ch[ch] = s1_row_nz_r ? signed'(buf_word[ch*E +: E]) : '0;
      sum_w[ch]  = PW'(rc_r[ch]) + PW'(buf_ch[ch]) + signed'(PW'(s1_pix_r[ch]));
      bit_w[ch]  = (sum_w[ch] >= thr_x);
      err_w[ch]  = bit_w[ch] ? sum_w[ch] - PW'(PIX_MAX) : sum_w[ch];

      // 7/16 right, 3/16 lower-left, 5/16 below, 1/16 lower-right
      rc_nxt[ch]  = s1_last_col_r ? '0
                  : sat_e(div16((err_w[ch] <<< 3) - err_w[ch]));
      pb0_new[ch] = sat_e(PW'(pb1_r[ch]) + div16((err_w[ch] <<< 2) + err_w[ch]));
      pb0_nxt[ch] = s1_last_col_r ? '0 : pb0_new[ch];
      pb1_nxt[ch] = s1_last_col_r ? '0 : sat_e(div16(err_w[ch]));

      left_word[ch*E +: E] = sat_e(PW'(pb0_r[ch])
                                   + div16((err_w[ch] <<< 1) + err_w[ch]));
      cur_word[ch*E +: E]  = pb0_new[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < 3; ch++) begin
        rc_r[ch]  <= '0;
        pb0_r[ch] <= '0;
        pb1_r[ch] <= '0;
      end
    end else if (s1_adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        rc_r[ch]  <= rc_nxt[ch];
        pb0_r[ch] <= pb0_nxt[ch];
        pb1_r[ch] <= pb1_nxt[ch];
      end
    end
  end

  // Buffer writes: lower-left entry and, on the last column, the current one
  logic [CW-1:0] left_col;
  logic          left_v;

  assign left_col = s1_col_r - CW'(1);
  assign left_v   = (s1_col_r != '0);

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      wr_hit[b]    = 1'b0;
      wr_addr_n[b] = BAW'(s1_col_r >> 1);
      wr_data_n[b] = cur_word;
      if (left_v && (left_col[0] == 1'(b))) begin
        wr_hit[b]    = s1_adv;
        wr_addr_n[b] = BAW'(left_col >> 1);
        wr_data_n[b] = left_word;
      end else if (s1_last_col_r && (s1_col_r[0] == 1'(b))) begin
        wr_hit[b] = s1_adv;
      end
      bank_we[b] = clr_active_r || wr_hit[b];
      bank_wa[b] = clr_active_r ? clr_cnt_r : wr_addr_n[b];
      bank_wd[b] = clr_active_r ? '0 : wr_data_n[b];
    end
  end

  // Forward a write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r[0] <= 1'b0;
      fwd_hit_r[1] <= 1'b0;
    end else if (in_acc) begin
      for (int b = 0; b < 2; b++) begin
        fwd_hit_r[b] <= wr_hit[b] && (wr_addr_n[b] == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int b = 0; b < 2; b++) begin
        fwd_data_r[b] <= wr_data_n[b];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  logic [2:0] out_bits_r;
  logic       out_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_bits_r <= bit_w;
      out_eof_r  <= s1_eof_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_out      = out_bits_r[0];
  assign out_green_out    = out_bits_r[1];
  assign out_blue_out     = out_bits_r[2];
  assign out_end_of_frame = out_eof_r;

  // ---------------------------------------------------------------------------
  // Assertions
  a_no_pixel_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !clr_active_r)
    else $error("pixel beat taken while line buffer clears");

  a_pixel_reaches_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted pixel missing from compute stage");

  a_last_col_two_banks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_col_r && left_v) |-> (wr_hit[0] && wr_hit[1]))
    else $error("last column must write both banks");

  a_row_end_clears_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_col_r) |=>
      (rc_r[0] == '0 && rc_r[1] == '0 && rc_r[2] == '0 &&
       pb1_r[0] == '0 && pb0_r[0] == '0))
    else $error("carried error not cleared at row end");

endmodule
